// ===== design/mrtu_pkg.sv =====
// Shared types, codes and the CRC-16 byte update for the RTU frame checker.
package mrtu_pkg;

  localparam int MaxFrame  = 256;
  localparam int CntW      = $clog2(MaxFrame + 1);
  localparam int MinFrame  = 4;
  localparam int HeldDepth = 2;
  localparam int BatchMax  = 5;
  localparam int BatchIdxW = $clog2(BatchMax);
  localparam int BatchCntW = $clog2(BatchMax + 1);

  localparam logic [15:0] CrcSeed = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [7:0]  ExcFlag = 8'h80;
  localparam logic [7:0]  BcastAddr = 8'h00;
  localparam logic [7:0]  DevAddrReset = 8'h01;

  // opcodes
  localparam logic [1:0] OpRx     = 2'd0;
  localparam logic [1:0] OpReply  = 2'd1;
  localparam logic [1:0] OpExcept = 2'd2;

  // result kinds
  localparam logic [1:0] KindFwd     = 2'd0;
  localparam logic [1:0] KindVerdict = 2'd1;
  localparam logic [1:0] KindTx      = 2'd2;

  // verdicts
  localparam logic [2:0] VerUnicast  = 3'd0;
  localparam logic [2:0] VerBcast    = 3'd1;
  localparam logic [2:0] VerShort    = 3'd2;
  localparam logic [2:0] VerBadCrc   = 3'd3;
  localparam logic [2:0] VerOtherAdr = 3'd4;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic       fin;
    logic [7:0] exc;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] verdict;
    logic       end_mark;
  } result_t;

  typedef result_t [BatchMax-1:0] batch_t;

  typedef struct packed {
    logic [15:0]     rx_crc;
    logic [15:0]     tx_crc;
    logic [CntW-1:0] rx_cnt;
    logic [7:0]      held0;
    logic [7:0]      held1;
    logic [7:0]      frame_addr;
    logic [7:0]      func;
    logic            was_bcast;
    logic            reply_open;
  } state_t;

  localparam state_t StateReset = '{
    rx_crc: CrcSeed, tx_crc: CrcSeed, rx_cnt: '0, held0: '0, held1: '0,
    frame_addr: '0, func: '0, was_bcast: 1'b0, reply_open: 1'b0
  };

  // one byte through the reflected CRC-16, bit at a time
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

  function automatic result_t mk_tx(input logic [7:0] b, input logic last);
    result_t r;
    r.kind     = KindTx;
    r.data     = b;
    r.verdict  = VerUnicast;
    r.end_mark = last;
    return r;
  endfunction

endpackage

// ===== design/mrtu_step.sv =====
// Next-state and result batch for one request: receive checking and reply framing.
module mrtu_step (
  input  mrtu_pkg::item_t                  item_i,
  input  mrtu_pkg::state_t                 state_i,
  input  logic [7:0]                       dev_addr_i,
  output mrtu_pkg::state_t                 state_o,
  output mrtu_pkg::batch_t                 batch_o,
  output logic [mrtu_pkg::BatchCntW-1:0]   cnt_o
);

  logic [mrtu_pkg::BatchCntW-1:0] k;
  logic [7:0]                     fa;
  logic [15:0]                    rx_crc_n;
  logic [mrtu_pkg::CntW-1:0]      cnt_n;
  logic                           match;
  logic [2:0]                     ver;
  logic [15:0]                    c0, c1, c2, c3;
  logic [7:0]                     exc_func;

  always_comb begin
    state_o  = state_i;
    batch_o  = '0;
    k        = '0;
    fa       = state_i.frame_addr;
    rx_crc_n = '0;
    cnt_n    = '0;
    match    = 1'b0;
    ver      = mrtu_pkg::VerUnicast;
    c0       = mrtu_pkg::CrcSeed;
    c1       = '0;
    c2       = '0;
    c3       = '0;
    exc_func = state_i.func | mrtu_pkg::ExcFlag;

    case (item_i.op)
      mrtu_pkg::OpRx: begin
        if (state_i.rx_cnt == '0) fa = item_i.data;
        state_o.frame_addr = fa;
        if (state_i.rx_cnt == mrtu_pkg::CntW'(1)) state_o.func = item_i.data;
        rx_crc_n = mrtu_pkg::crc16_byte(state_i.rx_crc, item_i.data);
        match = (fa == mrtu_pkg::BcastAddr) || (fa == dev_addr_i);
        if ((state_i.rx_cnt > mrtu_pkg::CntW'(mrtu_pkg::HeldDepth)) && match) begin
          batch_o[k].kind     = mrtu_pkg::KindFwd;
          batch_o[k].data     = state_i.held0;
          batch_o[k].verdict  = mrtu_pkg::VerUnicast;
          batch_o[k].end_mark = 1'b0;
          k = k + 1'b1;
        end
        cnt_n = (state_i.rx_cnt < mrtu_pkg::CntW'(mrtu_pkg::MaxFrame)) ?
                state_i.rx_cnt + 1'b1 : state_i.rx_cnt;
        state_o.rx_crc = rx_crc_n;
        state_o.rx_cnt = cnt_n;
        state_o.held0  = state_i.held1;
        state_o.held1  = item_i.data;
        if (item_i.fin) begin
          if (cnt_n < mrtu_pkg::CntW'(mrtu_pkg::MinFrame)) ver = mrtu_pkg::VerShort;
          else if (rx_crc_n != '0)                         ver = mrtu_pkg::VerBadCrc;
          else if (fa == mrtu_pkg::BcastAddr)              ver = mrtu_pkg::VerBcast;
          else if (fa != dev_addr_i)                       ver = mrtu_pkg::VerOtherAdr;
          else                                             ver = mrtu_pkg::VerUnicast;
          batch_o[k].kind     = mrtu_pkg::KindVerdict;
          batch_o[k].data     = 8'h00;
          batch_o[k].verdict  = ver;
          batch_o[k].end_mark = 1'b1;
          k = k + 1'b1;
          state_o.was_bcast = (ver == mrtu_pkg::VerBcast);
          state_o.rx_crc    = mrtu_pkg::CrcSeed;
          state_o.rx_cnt    = '0;
          state_o.held0     = '0;
          state_o.held1     = '0;
        end
      end
      mrtu_pkg::OpReply: begin
        if (!state_i.was_bcast) begin
          if (state_i.reply_open) begin
            c1 = state_i.tx_crc;
          end else begin
            batch_o[k] = mrtu_pkg::mk_tx(dev_addr_i, 1'b0);
            k = k + 1'b1;
            c1 = mrtu_pkg::crc16_byte(c0, dev_addr_i);
          end
          batch_o[k] = mrtu_pkg::mk_tx(item_i.data, 1'b0);
          k = k + 1'b1;
          c2 = mrtu_pkg::crc16_byte(c1, item_i.data);
          state_o.reply_open = 1'b1;
          state_o.tx_crc     = c2;
          if (item_i.fin) begin
            batch_o[k] = mrtu_pkg::mk_tx(c2[7:0], 1'b0);
            k = k + 1'b1;
            batch_o[k] = mrtu_pkg::mk_tx(c2[15:8], 1'b1);
            k = k + 1'b1;
            state_o.reply_open = 1'b0;
            state_o.tx_crc     = mrtu_pkg::CrcSeed;
          end
        end
      end
      mrtu_pkg::OpExcept: begin
        if (!state_i.was_bcast) begin
          c1 = mrtu_pkg::crc16_byte(c0, dev_addr_i);
          c2 = mrtu_pkg::crc16_byte(c1, exc_func);
          c3 = mrtu_pkg::crc16_byte(c2, item_i.exc);
          batch_o[0] = mrtu_pkg::mk_tx(dev_addr_i, 1'b0);
          batch_o[1] = mrtu_pkg::mk_tx(exc_func, 1'b0);
          batch_o[2] = mrtu_pkg::mk_tx(item_i.exc, 1'b0);
          batch_o[3] = mrtu_pkg::mk_tx(c3[7:0], 1'b0);
          batch_o[4] = mrtu_pkg::mk_tx(c3[15:8], 1'b1);
          k = mrtu_pkg::BatchCntW'(mrtu_pkg::BatchMax);
          state_o.reply_open = 1'b0;
          state_o.tx_crc     = mrtu_pkg::CrcSeed;
        end
      end
      default: begin
        k = '0;
      end
    endcase
    cnt_o = k;
  end

endmodule

// ===== design/modbus_rtu_frame_check_and_reply.sv =====
// Top level: RTU frame checker and reply framer with input register and result batch.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------------
//   in      | in        | in_valid_i/in_stall_o  | opcode, in_byte, final_byte, exc. code
//   out     | out       | out_valid_o/out_stall_i| kind, out_byte, verdict, end_mark
//   cfg     | in        | cfg_we_i               | cfg_data_i -> device_address
//
// A request is registered, then evaluated combinationally (CRC updates unrolled);
// its 0..5 results land in a batch register, loaded when the held request commits.
// Results leave one per cycle while out_stall_i is low; with no
// output stall the input runs back to back while each request gives at most one.
// The held request waits while the batch has more than its last result to send.
// Reset (rst_ni low, async) seeds the CRCs, clears counters and flags, address = 1.
module modbus_rtu_frame_check_and_reply (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] in_byte_i,
  input  logic       final_byte_i,
  input  logic [7:0] exception_code_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic [2:0] verdict_o,
  output logic       end_mark_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i
);

  // device address register
  logic [7:0] dev_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= mrtu_pkg::DevAddrReset;
    end else if (cfg_we_i) begin
      dev_addr_q <= cfg_data_i;
    end
  end

  // input register
  mrtu_pkg::item_t item_q;
  logic            item_vld_q, item_vld_d;
  logic            in_acc, commit;

  // frame state
  mrtu_pkg::state_t state_q, state_d;

  // result batch
  mrtu_pkg::batch_t                batch_q, batch_d;
  logic [mrtu_pkg::BatchCntW-1:0]  batch_cnt_q, res_cnt;
  logic [mrtu_pkg::BatchIdxW-1:0]  idx_q;
  logic                            batch_vld_q;
  logic                            out_pop, out_last;
  mrtu_pkg::result_t               head;

  assign out_pop  = batch_vld_q && !out_stall_i;
  assign out_last = (mrtu_pkg::BatchCntW'(idx_q) == batch_cnt_q - 1'b1);

  // the held request moves on once the batch is empty or sending its last result
  assign commit     = item_vld_q && (!batch_vld_q || (out_pop && out_last));
  assign in_stall_o = item_vld_q && !commit;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign item_vld_d = in_acc ? 1'b1 : (commit ? 1'b0 : item_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.op   <= opcode_i;
      item_q.data <= in_byte_i;
      item_q.fin  <= final_byte_i;
      item_q.exc  <= exception_code_i;
    end
  end

  mrtu_step u_step (
    .item_i     (item_q),
    .state_i    (state_q),
    .dev_addr_i (dev_addr_q),
    .state_o    (state_d),
    .batch_o    (batch_d),
    .cnt_o      (res_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mrtu_pkg::StateReset;
      batch_vld_q <= 1'b0;
      batch_cnt_q <= '0;
      idx_q       <= '0;
    end else if (commit) begin
      state_q     <= state_d;
      batch_vld_q <= (res_cnt != '0);
      batch_cnt_q <= res_cnt;
      idx_q       <= '0;
    end else if (out_pop) begin
      if (out_last) begin
        batch_vld_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // batch payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (commit) begin
      batch_q <= batch_d;
    end
  end

  assign head        = batch_q[idx_q];
  assign out_valid_o = batch_vld_q;
  assign kind_o      = head.kind;
  assign out_byte_o  = head.data;
  assign verdict_o   = head.verdict;
  assign end_mark_o  = head.end_mark;

  // head index stays inside the filled part of the batch
  a_idx_in_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    batch_vld_q |-> (batch_cnt_q != '0) && (mrtu_pkg::BatchCntW'(idx_q) < batch_cnt_q))
    else $error("batch head index out of range");

  // a verdict carries no byte and always closes
  a_verdict_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == mrtu_pkg::KindVerdict)) |-> ((out_byte_o == 8'h00) && end_mark_o))
    else $error("malformed verdict result");

  // forwarded bytes never close anything
  a_fwd_no_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == mrtu_pkg::KindFwd)) |-> !end_mark_o)
    else $error("forwarded byte with end mark");

  // a final received byte resets the receive side
  a_rx_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (item_q.op == mrtu_pkg::OpRx) && item_q.fin) |=>
      ((state_q.rx_cnt == '0) && (state_q.rx_crc == mrtu_pkg::CrcSeed)))
    else $error("receive state not cleared after verdict");

  // replies after a broadcast produce nothing
  a_bcast_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && state_q.was_bcast && (item_q.op != mrtu_pkg::OpRx)) |=> !out_valid_o)
    else $error("reply sent after broadcast");

endmodule

// ===== tb/mrtu_frame_monitor.sv =====
// Monitor for the RTU frame checker: predicts the results of each request and checks them.
module mrtu_frame_monitor
  import mrtu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [1:0] opcode_i,
  input  logic [7:0] in_byte_i,
  input  logic       final_byte_i,
  input  logic [7:0] exception_code_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [1:0] kind_i,
  input  logic [7:0] out_byte_i,
  input  logic [2:0] verdict_i,
  input  logic       end_mark_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  output int         n_pending_o,
  output int         n_fail_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] VerNone = 3'd0;
  localparam int         ReportMax = 10;

  logic [15:0]     rx_crc;
  logic [15:0]     tx_crc;
  logic [CntW-1:0] rx_len;
  logic [7:0]      held_q [2];
  logic [7:0]      frame_adr;
  logic [7:0]      func_code;
  logic [7:0]      own_adr;
  logic            bcast_seen;
  logic            reply_busy;
  result_t         awaited_results [$];

  // serial form: feedback bit is the low CRC bit xor the next data bit
  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] s;
    s = c;
    for (int i = 0; i < 8; i++) begin
      s = (s[0] ^ d[i]) ? ((s >> 1) ^ CrcPoly) : (s >> 1);
    end
    return s;
  endfunction

  function automatic result_t pack_result(input logic [1:0] k, input logic [7:0] b,
                                          input logic [2:0] v, input logic last);
    result_t r;
    r.kind     = k;
    r.data     = b;
    r.verdict  = v;
    r.end_mark = last;
    return r;
  endfunction

  function automatic void emit_tx(input logic [7:0] b);
    tx_crc = crc_next(tx_crc, b);
    awaited_results.push_back(pack_result(KindTx, b, VerNone, 1'b0));
  endfunction

  // CRC low byte first, high byte closes the frame
  function automatic void emit_tx_crc();
    awaited_results.push_back(pack_result(KindTx, tx_crc[7:0], VerNone, 1'b0));
    awaited_results.push_back(pack_result(KindTx, tx_crc[15:8], VerNone, 1'b1));
    tx_crc     = CrcSeed;
    reply_busy = 1'b0;
  endfunction

  function automatic void clear_rx();
    rx_crc    = CrcSeed;
    rx_len    = '0;
    held_q[0] = '0;
    held_q[1] = '0;
  endfunction

  function automatic void predict_results(input item_t req);
    logic [CntW-1:0] pos;
    logic [2:0]      v;
    case (req.op)
      OpRx: begin
        pos = rx_len;
        if (pos == 0) frame_adr = req.data;
        if (pos == 1) func_code = req.data;
        rx_crc = crc_next(rx_crc, req.data);
        // two-byte delay keeps address and CRC out of the forwarded stream
        if (pos >= 3 && (frame_adr == BcastAddr || frame_adr == own_adr)) begin
          awaited_results.push_back(pack_result(KindFwd, held_q[0], VerNone, 1'b0));
        end
        held_q[0] = held_q[1];
        held_q[1] = req.data;
        if (rx_len < MaxFrame) rx_len = rx_len + 1'b1;
        if (req.fin) begin
          if (rx_len < MinFrame)          v = VerShort;
          else if (rx_crc != 16'h0000)    v = VerBadCrc;
          else if (frame_adr == BcastAddr) v = VerBcast;
          else if (frame_adr != own_adr)  v = VerOtherAdr;
          else                            v = VerUnicast;
          awaited_results.push_back(pack_result(KindVerdict, 8'h00, v, 1'b1));
          bcast_seen = (v == VerBcast);
          clear_rx();
        end
      end
      OpReply: begin
        if (!bcast_seen) begin
          if (!reply_busy) begin
            tx_crc     = CrcSeed;
            reply_busy = 1'b1;
            emit_tx(own_adr);
          end
          emit_tx(req.data);
          if (req.fin) emit_tx_crc();
        end
      end
      OpExcept: begin
        if (!bcast_seen) begin
          tx_crc = CrcSeed;
          emit_tx(own_adr);
          emit_tx(func_code | ExcFlag);
          emit_tx(req.exc);
          emit_tx_crc();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void note_failure(input string msg);
    n_fail_o++;
    if (n_fail_o <= ReportMax) $display("mismatch #%0d: %s", n_fail_o, msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    item_t   req;
    if (!rst_ni) begin
      own_adr    = DevAddrReset;
      clear_rx();
      tx_crc     = CrcSeed;
      frame_adr  = '0;
      func_code  = '0;
      bcast_seen = 1'b0;
      reply_busy = 1'b0;
      awaited_results.delete();
      n_fail_o   = 0;
    end else begin
      // results first: nothing accepted at this edge can have produced one yet
      if (out_valid_i && !out_stall_i) begin
        got = pack_result(kind_i, out_byte_i, verdict_i, end_mark_i);
        if (awaited_results.size() == 0) begin
          note_failure($sformatf("unexpected kind=%0d byte=%02h verdict=%0d end=%0b",
                                 got.kind, got.data, got.verdict, got.end_mark));
        end else begin
          want = awaited_results.pop_front();
          if (got.kind !== want.kind || got.data !== want.data ||
              got.verdict !== want.verdict || got.end_mark !== want.end_mark) begin
            note_failure($sformatf(
              "want kind=%0d byte=%02h verdict=%0d end=%0b, got kind=%0d byte=%02h verdict=%0d end=%0b",
              want.kind, want.data, want.verdict, want.end_mark,
              got.kind, got.data, got.verdict, got.end_mark));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        req.op   = opcode_i;
        req.data = in_byte_i;
        req.fin  = final_byte_i;
        req.exc  = exception_code_i;
        predict_results(req);
      end
      if (cfg_we_i) own_adr = cfg_data_i;
    end
    n_pending_o = awaited_results.size();
  end

endmodule

// ===== tb/tb_modbus_rtu_frame_check_and_reply.sv =====
// Testbench top for the RTU frame checker: clock, reset, request stimulus and the verdict.
module tb_modbus_rtu_frame_check_and_reply;
  timeunit 1ns;
  timeprecision 1ps;
  import mrtu_pkg::*;

  // opcode the block must ignore
  localparam logic [1:0] OpSpare = 2'd3;

  localparam int QuietLimit  = 1000;  // cycles with no transfer on either channel
  localparam int HoldOff     = 6;     // settle time before a register write
  localparam int DrainCycles = 20;    // tail after the last expected result
  localparam int PhaseQuota  = 22;    // counted requests per address setting
  localparam int LongPdu     = 258;   // pushes the byte count past saturation
  localparam int StallRunMax = 8;

  typedef enum {FrameGood, FrameBadCrc, FrameShort} frame_flaw_e;
  typedef enum {StallNone, StallLight, StallHeavy} stall_mode_e;

  // every block input starts at a known value
  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       in_valid_i       = 1'b0;
  logic [1:0] opcode_i         = OpRx;
  logic [7:0] in_byte_i        = 8'h00;
  logic       final_byte_i     = 1'b0;
  logic [7:0] exception_code_i = 8'h00;
  logic       out_stall_i      = 1'b0;
  logic       cfg_we_i         = 1'b0;
  logic [7:0] cfg_data_i       = 8'h00;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [1:0] kind_o;
  logic [7:0] out_byte_o;
  logic [2:0] verdict_o;
  logic       end_mark_o;

  int n_pending;
  int n_fail;

  // stimulus bookkeeping
  logic [7:0] own_adr     = DevAddrReset;
  bit         last_bcast  = 1'b0;  // replies are swallowed after a good broadcast
  bit         tally_on    = 1'b1;
  int         items_sent  = 0;
  int         burst_left  = 0;
  int         quiet_cycles = 0;

  // receiver pattern state
  stall_mode_e stall_mode = StallNone;
  int          stall_left = 0;
  int          stall_run  = 0;
  bit          stall_now;

  modbus_rtu_frame_check_and_reply i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .in_byte_i        (in_byte_i),
    .final_byte_i     (final_byte_i),
    .exception_code_i (exception_code_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .out_byte_o       (out_byte_o),
    .verdict_o        (verdict_o),
    .end_mark_o       (end_mark_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i)
  );

  mrtu_frame_monitor i_monitor (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .opcode_i         (opcode_i),
    .in_byte_i        (in_byte_i),
    .final_byte_i     (final_byte_i),
    .exception_code_i (exception_code_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_i           (kind_o),
    .out_byte_i       (out_byte_o),
    .verdict_i        (verdict_o),
    .end_mark_i       (end_mark_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .n_pending_o      (n_pending),
    .n_fail_o         (n_fail)
  );

  // 4 ns period, first rising edge at 2 ns
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver: phases of no stall, light stall and heavy stall. A stall run is
  // cut short once it reaches StallRunMax so the output never sits blocked for long.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      stall_left = $urandom_range(5, 60);
    end
    stall_left--;
    case (stall_mode)
      StallLight: stall_now = ($urandom_range(0, 3) == 0);
      StallHeavy: stall_now = ($urandom_range(0, 1) == 1);
      default:    stall_now = 1'b0;
    endcase
    if (stall_run >= StallRunMax) stall_now = 1'b0;
    stall_run = stall_now ? stall_run + 1 : 0;
    out_stall_i <= stall_now;
  end

  // Watchdog: a run that stops moving on both channels is a failure.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Sender pacing: bursts of random length, sometimes long ones with no idling,
  // separated by random gaps (zero included). Called at a falling edge.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
  endtask

  // One request: driven at a falling edge, held until a rising edge sees no
  // stall, returns at the next falling edge with valid still high so the next
  // request can follow back to back.
  task automatic push_request(input logic [1:0] op, input logic [7:0] data,
                              input logic fin, input logic [7:0] exc);
    pace();
    in_valid_i       <= 1'b1;
    opcode_i         <= op;
    in_byte_i        <= data;
    final_byte_i     <= fin;
    exception_code_i <= exc;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    // ignored requests do not count toward the stimulus length
    if (tally_on && op != OpSpare && (op == OpRx || !last_bcast)) items_sent++;
  endtask

  // Received frame: address, PDU, CRC low/high. A bad-CRC frame gets one bit
  // flipped anywhere; a short frame is cut to 1..3 bytes.
  task automatic send_rx_frame(input logic [7:0] adr, input int pdu_len,
                               input frame_flaw_e flaw);
    logic [7:0]  frame_q [$];
    logic [15:0] crc;
    int          pos;
    int          keep;
    frame_q.push_back(adr);
    repeat (pdu_len) frame_q.push_back(8'($urandom));
    crc = CrcSeed;
    foreach (frame_q[i]) crc = crc16_byte(crc, frame_q[i]);
    frame_q.push_back(crc[7:0]);
    frame_q.push_back(crc[15:8]);
    case (flaw)
      FrameBadCrc: begin
        pos = $urandom_range(0, frame_q.size() - 1);
        frame_q[pos] = frame_q[pos] ^ (8'h01 << $urandom_range(0, 7));
      end
      FrameShort: begin
        keep = $urandom_range(1, 3);
        while (frame_q.size() > keep) void'(frame_q.pop_back());
      end
      default: ;
    endcase
    foreach (frame_q[i]) begin
      push_request(OpRx, frame_q[i], i == frame_q.size() - 1, 8'($urandom));
    end
    // an empty PDU still carries a sound CRC but is judged too short
    last_bcast = (flaw == FrameGood && adr == BcastAddr && pdu_len > 0);
  endtask

  // Reply PDU bytes; left open when not closing, so a later reply byte or an
  // exception request finds it still running.
  task automatic send_reply(input int n, input bit closing);
    for (int k = 0; k < n; k++) begin
      push_request(OpReply, 8'($urandom), closing && k == n - 1, 8'($urandom));
    end
  endtask

  // Unstructured requests: any opcode, frames broken off at random.
  task automatic send_noise(input int n);
    logic [1:0] op;
    logic       fin;
    repeat (n) begin
      op  = 2'($urandom);
      fin = ($urandom_range(0, 3) == 0);
      push_request(op, 8'($urandom), fin, 8'($urandom));
      if (op == OpRx && fin) last_bcast = 1'b0;
    end
  endtask

  // Mostly our own address, then broadcast, then anyone else (248..255 too).
  function automatic logic [7:0] pick_address();
    logic [7:0] a;
    int         roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return own_adr;
    if (roll < 8) return BcastAddr;
    do begin
      a = 8'($urandom_range(1, 255));
    end while (a == own_adr);
    return a;
  endfunction

  // Small PDUs mostly, zero included.
  function automatic int pick_pdu_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
  endfunction

  // Address change only with the block idle: nothing outstanding, then a
  // settle time for requests that produce no result.
  task automatic write_address(input logic [7:0] a);
    in_valid_i <= 1'b0;
    while (n_pending != 0) @(negedge clk_i);
    repeat (HoldOff) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= a;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    own_adr    = a;
  endtask

  // Random mix, weighted toward well-formed frames and replies.
  task automatic run_random_phase(input int quota);
    int stop_at;
    int pick;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)      send_rx_frame(pick_address(), pick_pdu_len(), FrameGood);
      else if (pick < 55) send_rx_frame(pick_address(), pick_pdu_len(), FrameBadCrc);
      else if (pick < 62) send_rx_frame(pick_address(), 2, FrameShort);
      else if (pick < 80) send_reply($urandom_range(1, 6), $urandom_range(0, 4) != 0);
      else if (pick < 92) push_request(OpExcept, 8'($urandom), 1'($urandom), 8'($urandom));
      else                send_noise($urandom_range(1, 4));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // --- directed part, device address at its reset value ---
    // lone byte: too short, address byte at the top of its range
    push_request(OpRx, 8'hFF, 1'b1, 8'h00);
    // minimal sound unicast frame: one forwarded byte, then the verdict
    send_rx_frame(DevAddrReset, 1, FrameGood);
    // reply that closes on its first byte, then an exception reply
    push_request(OpReply, 8'h00, 1'b1, 8'hFF);
    push_request(OpExcept, 8'hFF, 1'b0, 8'hFF);
    // good broadcast: both reply kinds must be suppressed
    send_rx_frame(BcastAddr, 1, FrameGood);
    push_request(OpReply, 8'hFF, 1'b1, 8'h00);
    push_request(OpExcept, 8'h00, 1'b1, 8'h00);
    push_request(OpSpare, 8'hFF, 1'b1, 8'hFF);
    // bad CRC still updates the stored function code used by the exception
    send_rx_frame(DevAddrReset, 1, FrameBadCrc);
    push_request(OpExcept, 8'h5A, 1'b1, 8'h00);
    // sound frame for someone else: nothing forwarded
    send_rx_frame(8'hF7, 1, FrameGood);
    // open reply dropped by an exception request
    push_request(OpReply, 8'h11, 1'b0, 8'h00);
    push_request(OpExcept, 8'h22, 1'b0, 8'hFF);

    // --- random part over several address settings ---
    write_address(8'd247);
    run_random_phase(PhaseQuota);

    write_address(DevAddrReset);
    // frame longer than the count range, kept out of the tally
    tally_on = 1'b0;
    send_rx_frame(own_adr, LongPdu, FrameGood);
    tally_on = 1'b1;
    run_random_phase(PhaseQuota);

    write_address(8'($urandom_range(2, 246)));
    run_random_phase(PhaseQuota);

    write_address(8'($urandom_range(1, 247)));
    run_random_phase(PhaseQuota);

    // --- wind down: everything expected must arrive, then a quiet tail ---
    in_valid_i <= 1'b0;
    while (n_pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
